>>> rtl/packet_length_minimizer_assert.svh
// ----------------------------------------------------------------------------
// Packet length minimizer assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PACKET_LENGTH_MINIMIZER_ASSERT_SVH
`define PACKET_LENGTH_MINIMIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PLM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plm check failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define PLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plm check failed: next-cycle implication");

`endif

>>> rtl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared constants, payload types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package plm_pkg;

   localparam int MAX_FRAME      = 64;
   localparam int FRAME_OVERHEAD = 6;
   localparam int HDR_LEN        = FRAME_OVERHEAD - 1;

   localparam int LEN_W     = 7;
   localparam int BYTE_W    = 8;
   localparam int MS_W      = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [MS_W-1:0] MS_MAX = '1;

   // input item kinds
   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;

   // mutation codes
   localparam logic [1:0] MUT_NONE    = 2'd0;
   localparam logic [1:0] MUT_BAD_CHK = 2'd1;
   localparam logic [1:0] MUT_SYNC    = 2'd2;
   localparam logic [1:0] MUT_LEN     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_BYTE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_BYTE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVER_TMO    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSERVE_WINDOW = 2'd3;

   localparam logic [BYTE_W-1:0] SYNC_RESET     = 8'hA5;
   localparam logic [BYTE_W-1:0] COMMAND_RESET  = 8'h01;
   localparam logic [MS_W-1:0]   RECOVER_RESET  = 16'd2000;
   localparam logic [MS_W-1:0]   OBSERVE_RESET  = 16'd500;
   localparam logic [BYTE_W-1:0] BYTE_ONES      = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_ZERO      = 8'h00;

   // frame header positions
   localparam logic [LEN_W-1:0] POS_SYNC = 7'd0;
   localparam logic [LEN_W-1:0] POS_CMD  = 7'd1;
   localparam logic [LEN_W-1:0] POS_LEN  = 7'd2;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT,
      PH_SEND,
      PH_OBSERVE
   } phase_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [LEN_W-1:0] original_len;
      logic [1:0]       mutation_code;
      logic             heartbeat_alive;
      logic             heartbeat_seen;
   } req_type;

   typedef struct packed {
      logic              byte_valid;
      logic [BYTE_W-1:0] packet_byte;
      logic              last;
      logic              finished;
      logic              cancelled;
      logic [LEN_W-1:0]  best_len;
      logic              clear_detector;
      logic              busy_res;
   } rsp_type;

   typedef struct packed {
      logic step;         // apply the accepted item to the search state
      logic start_frame;  // rewind the frame byte counter
      logic load_status;  // load the status result into the output register
      logic load_byte;    // load the next frame byte into the output register
   } ctl_cmd_type;

   typedef struct packed {
      logic emit_frame;   // the offered item sends a probe frame
      logic last_byte;    // the byte counter is on the final frame byte
   } dp_sts_type;

endpackage

>>> rtl/plm_ctrl.sv
// ----------------------------------------------------------------------------
// plm_ctrl
// Handshake sequencer: takes items, streams frame bytes, owns output valid.
// ----------------------------------------------------------------------------
module plm_ctrl
   import plm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ctl_cmd_type cmd,
   input  dp_sts_type  sts
);

   typedef enum logic {
      CTL_ITEM,
      CTL_FRAME
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      accept       = 1'b0;
      unique case (state_ff)
         CTL_ITEM: begin
            req_stall = !out_free;
            accept    = req_valid && out_free;
            cmd.step  = accept;
            if (accept && sts.emit_frame) begin
               cmd.start_frame = 1'b1;
               state_in        = CTL_FRAME;
            end else if (accept) begin
               cmd.load_status = 1'b1;
               rsp_valid_in    = 1'b1;
            end
         end
         CTL_FRAME: begin
            if (out_free) begin
               cmd.load_byte = 1'b1;
               rsp_valid_in  = 1'b1;
               if (sts.last_byte) begin
                  state_in = CTL_ITEM;
               end
            end
         end
         default: begin
            state_in = CTL_ITEM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_ITEM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/plm_dp.sv
// ----------------------------------------------------------------------------
// plm_dp
// Search state, configuration registers, frame byte generator, output data.
// ----------------------------------------------------------------------------
module plm_dp
   import plm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_cmd_type          cmd,
   output dp_sts_type           sts,
   input  req_type              req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output rsp_type              rsp_data
);

   logic [BYTE_W-1:0] sync_ff, command_ff;
   logic [MS_W-1:0]   timeout_ff, window_ff;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  lower_ff, lower_in;
   logic [LEN_W-1:0]  upper_ff, upper_in;
   logic [LEN_W-1:0]  probe_ff, probe_in;
   logic [LEN_W-1:0]  shortest_ff, shortest_in;
   logic [MS_W-1:0]   elapsed_ff, elapsed_in;
   logic [1:0]        mut_ff, mut_in;

   logic [LEN_W-1:0]  pos_ff;
   logic [BYTE_W-1:0] chk_ff;
   rsp_type           rsp_data_ff;

   logic [MS_W-1:0]   elapsed_inc;
   logic [LEN_W-1:0]  olen_clamp;
   logic [LEN_W:0]    lower_p1;
   logic [LEN_W:0]    mid_sum;
   logic              fin, canc, clr, emit;

   logic [LEN_W-1:0]  pay;
   logic [LEN_W:0]    chk_pos;
   logic [BYTE_W-1:0] raw_byte, frame_byte;
   rsp_type           status_rsp, byte_rsp;

   // ---- search step ----
   always_comb begin
      elapsed_inc = (elapsed_ff == MS_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      olen_clamp  = (req_data.original_len > LEN_W'(MAX_FRAME)) ?
                    LEN_W'(MAX_FRAME) : req_data.original_len;
      lower_p1    = {1'b0, lower_ff} + 1'b1;
      mid_sum     = {1'b0, lower_ff} + {1'b0, upper_ff};

      phase_in    = phase_ff;
      lower_in    = lower_ff;
      upper_in    = upper_ff;
      probe_in    = probe_ff;
      shortest_in = shortest_ff;
      elapsed_in  = elapsed_ff;
      mut_in      = mut_ff;
      fin         = 1'b0;
      canc        = 1'b0;
      clr         = 1'b0;
      emit        = 1'b0;

      unique case (req_data.kind)
         KIND_START: begin
            probe_in    = olen_clamp;
            shortest_in = olen_clamp;
            lower_in    = LEN_W'(FRAME_OVERHEAD + 1);
            upper_in    = olen_clamp;
            mut_in      = req_data.mutation_code;
            elapsed_in  = '0;
            phase_in    = PH_WAIT;
         end
         KIND_CANCEL: begin
            if (phase_ff != PH_IDLE) begin
               phase_in = PH_IDLE;
               canc     = 1'b1;
            end
         end
         KIND_TICK: begin
            if (phase_ff != PH_IDLE) begin
               elapsed_in = elapsed_inc;
            end
            unique case (phase_ff)
               PH_WAIT: begin
                  if (req_data.heartbeat_alive) begin
                     if ({1'b0, upper_ff} <= lower_p1) begin
                        phase_in = PH_IDLE;
                        fin      = 1'b1;
                     end else begin
                        probe_in   = mid_sum[LEN_W:1];
                        phase_in   = PH_SEND;
                        elapsed_in = '0;
                     end
                  end else if (elapsed_inc > timeout_ff) begin
                     phase_in = PH_IDLE;
                     fin      = 1'b1;
                  end
               end
               PH_SEND: begin
                  phase_in   = PH_OBSERVE;
                  elapsed_in = '0;
                  emit       = probe_ff > LEN_W'(FRAME_OVERHEAD);
               end
               PH_OBSERVE: begin
                  if (!req_data.heartbeat_alive && req_data.heartbeat_seen) begin
                     shortest_in = probe_ff;
                     upper_in    = probe_ff;
                     clr         = 1'b1;
                     phase_in    = PH_WAIT;
                     elapsed_in  = '0;
                  end else if (elapsed_inc >= window_ff) begin
                     lower_in   = probe_ff;
                     phase_in   = PH_WAIT;
                     elapsed_in = '0;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // ---- frame byte generator ----
   always_comb begin
      pay     = probe_ff - LEN_W'(FRAME_OVERHEAD);
      chk_pos = {1'b0, pay} + (LEN_W + 1)'(HDR_LEN);

      raw_byte = BYTE_ZERO;
      priority if (pos_ff == POS_CMD) begin
         raw_byte = command_ff;
      end else if (pos_ff == POS_LEN) begin
         raw_byte = BYTE_W'(pay);
      end else if ({1'b0, pos_ff} >= (LEN_W + 1)'(HDR_LEN) && {1'b0, pos_ff} < chk_pos) begin
         raw_byte = BYTE_W'(pos_ff - LEN_W'(HDR_LEN));
      end else begin
         raw_byte = BYTE_ZERO;
      end

      priority if (pos_ff == POS_SYNC) begin
         frame_byte = (mut_ff == MUT_SYNC) ? BYTE_ONES : sync_ff;
      end else if (pos_ff == POS_LEN && mut_ff == MUT_LEN) begin
         frame_byte = BYTE_ONES;
      end else if ({1'b0, pos_ff} == chk_pos) begin
         frame_byte = (mut_ff == MUT_BAD_CHK) ? ~chk_ff : chk_ff;
      end else begin
         frame_byte = raw_byte;
      end
   end

   assign sts.emit_frame = emit;
   assign sts.last_byte  = pos_ff == (probe_ff - LEN_W'(1));

   always_comb begin
      status_rsp                = '0;
      status_rsp.last           = 1'b1;
      status_rsp.finished       = fin;
      status_rsp.cancelled      = canc;
      status_rsp.best_len       = shortest_in;
      status_rsp.clear_detector = clr;
      status_rsp.busy_res       = phase_in != PH_IDLE;

      byte_rsp             = '0;
      byte_rsp.byte_valid  = 1'b1;
      byte_rsp.packet_byte = frame_byte;
      byte_rsp.last        = sts.last_byte;
      byte_rsp.best_len    = shortest_ff;
      byte_rsp.busy_res    = phase_ff != PH_IDLE;
   end

   // ---- control and configuration state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff     <= SYNC_RESET;
         command_ff  <= COMMAND_RESET;
         timeout_ff  <= RECOVER_RESET;
         window_ff   <= OBSERVE_RESET;
         phase_ff    <= PH_IDLE;
         lower_ff    <= '0;
         upper_ff    <= '0;
         probe_ff    <= '0;
         shortest_ff <= '0;
         elapsed_ff  <= '0;
         mut_ff      <= MUT_NONE;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SYNC_BYTE:      sync_ff    <= csr_wdata[BYTE_W-1:0];
               CSR_COMMAND_BYTE:   command_ff <= csr_wdata[BYTE_W-1:0];
               CSR_RECOVER_TMO:    timeout_ff <= csr_wdata[MS_W-1:0];
               CSR_OBSERVE_WINDOW: window_ff  <= csr_wdata[MS_W-1:0];
               default:            sync_ff    <= sync_ff;
            endcase
         end
         if (cmd.step) begin
            phase_ff    <= phase_in;
            lower_ff    <= lower_in;
            upper_ff    <= upper_in;
            probe_ff    <= probe_in;
            shortest_ff <= shortest_in;
            elapsed_ff  <= elapsed_in;
            mut_ff      <= mut_in;
         end
      end
   end

   // ---- frame counter, running checksum and output data ----
   always_ff @(posedge clock) begin
      if (cmd.start_frame) begin
         pos_ff <= '0;
         chk_ff <= BYTE_ZERO;
      end else if (cmd.load_byte) begin
         pos_ff <= pos_ff + 1'b1;
         chk_ff <= chk_ff ^ raw_byte;
      end
      if (cmd.load_status) begin
         rsp_data_ff <= status_rsp;
      end else if (cmd.load_byte) begin
         rsp_data_ff <= byte_rsp;
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

>>> rtl/packet_length_minimizer.sv
// ----------------------------------------------------------------------------
// packet_length_minimizer
// Binary search for the shortest probe frame that still crashes a target.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : input transactions. A start transaction loads the failing length
//            and mutation; each tick transaction (one per millisecond) carries
//            the heartbeat levels; a cancel transaction stops the search.
//   rsp_*  : result transactions. Every input transaction yields one status
//            result, except the tick that sends a probe, which yields one
//            result per frame byte (last marks the final one).
//   csr_*  : register writes (sync byte, command byte, recovery timeout,
//            observe window); the user must make them only while no
//            transaction is in flight, which the block does not enforce.
// Timing: a status result is registered, ready in the cycle after its input
//   transaction; a probe of N bytes streams one byte per cycle while the
//   output is not stalled, paced by the single frame byte counter.
// Reset: the search goes idle, all bounds clear and the registers return to
//   their defaults; no result is pending.
// Stall: rsp_stall holds the output register; while it is full and stalled
//   req_stall rises, and req_stall stays high for the whole frame stream.
// ----------------------------------------------------------------------------
module packet_length_minimizer
   import plm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   // sequence transactions and frame bytes
   plm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // hold search state, build frame bytes, drive result data
   plm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

`include "packet_length_minimizer_assert.svh"

   // no input transaction may be taken while a frame byte is loaded
   `PLM_ASSERT_SAME(a_no_step_in_frame, clock, reset, cmd.load_byte, !cmd.step)
   // a probe frame only goes out during an active search
   `PLM_ASSERT_SAME(a_frame_busy, clock, reset, rsp_valid && rsp_data.byte_valid, rsp_data.busy_res)
   // an ended search never reports busy
   `PLM_ASSERT_SAME(a_end_idle, clock, reset, rsp_valid && (rsp_data.finished || rsp_data.cancelled), !rsp_data.busy_res)
   // input holds off once a frame stream starts
   `PLM_ASSERT_NEXT(a_frame_stalls_req, clock, reset, cmd.start_frame, req_stall)

endmodule

>>> tb/sv/tb_packet_length_minimizer.sv
// ----------------------------------------------------------------------------
// tb_packet_length_minimizer
// Self-checking bench for the probe frame length search.
// A directed table covers idle ticks, cancels, unused kinds, clamped and
// closed ranges, restarts and probe frames for several mutations. Random
// searches then run under four register settings, the extremes among them.
// Each accepted transaction runs through a cycle-free model of the search,
// and every result transaction is checked in order against it.
// ----------------------------------------------------------------------------
module tb_packet_length_minimizer;
   timeunit 1ns;
   timeprecision 1ps;
   import plm_pkg::*;

   // the fourth kind value has no meaning in the block; it must act as a no-op
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 10;

   // ----- block ports; every input starts at a known value -----
   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SYNC_BYTE;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // ----- model of the search: registers and state -----
   logic [BYTE_W-1:0] cfg_sync;
   logic [BYTE_W-1:0] cfg_cmd;
   logic [MS_W-1:0]   cfg_recover;
   logic [MS_W-1:0]   cfg_observe;
   phase_type         srch_phase;
   logic [LEN_W-1:0]  lo_bound;
   logic [LEN_W-1:0]  hi_bound;
   logic [LEN_W-1:0]  probe_len;
   logic [LEN_W-1:0]  best_fail;
   logic [MS_W-1:0]   elapsed;
   logic [1:0]        held_mut;

   // frame bytes and status results still owed by the block, oldest first
   rsp_type frame_status_q[$];

   // directed table
   req_type dir_item[$];
   bit      dir_typed[$];
   rsp_type dir_exp[$];

   int      mismatches  = 0;
   int      cycle_count = 0;
   int      burst_left  = 0;

   // receiver state
   bit      hold_request = 1'b0;
   int      hold_left    = 0;
   int      stall_mode   = 0;
   int      mode_left    = 0;
   rsp_type want_rsp;

   packet_length_minimizer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic req_type make_req(input logic [1:0] kind, input int len,
                                        input logic [1:0] mut, input int alive,
                                        input int seen);
      req_type r;
      r.kind            = kind;
      r.original_len    = LEN_W'(len);
      r.mutation_code   = mut;
      r.heartbeat_alive = (alive != 0);
      r.heartbeat_seen  = (seen != 0);
      return r;
   endfunction

   // Status result as typed into the table: no frame byte, no clear request.
   function automatic rsp_type status_rsp(input int fin, input int canc,
                                          input int best, input int busy);
      rsp_type s;
      s           = '0;
      s.last      = 1'b1;
      s.finished  = (fin != 0);
      s.cancelled = (canc != 0);
      s.best_len  = LEN_W'(best);
      s.busy_res  = (busy != 0);
      return s;
   endfunction

   task automatic add_row(input req_type r, input int typed, input rsp_type e);
      dir_item.push_back(r);
      dir_typed.push_back(typed != 0);
      dir_exp.push_back(e);
   endtask

   // Apply one accepted transaction to the search model and queue the results
   // it owes: a whole probe frame on the sending tick, else one status result.
   task automatic minimize_step(input req_type r);
      logic [BYTE_W-1:0] pay;
      logic [BYTE_W-1:0] chk;
      logic [BYTE_W-1:0] b;
      rsp_type           res;
      logic              fin;
      logic              canc;
      logic              clr;
      fin  = 1'b0;
      canc = 1'b0;
      clr  = 1'b0;
      case (r.kind)
         KIND_START: begin
            // lengths past the frame limit clamp; a restart drops the old search
            probe_len  = (r.original_len > MAX_FRAME) ? LEN_W'(MAX_FRAME) : r.original_len;
            best_fail  = probe_len;
            hi_bound   = probe_len;
            lo_bound   = LEN_W'(FRAME_OVERHEAD + 1);
            held_mut   = r.mutation_code;
            elapsed    = '0;
            srch_phase = PH_WAIT;
         end
         KIND_CANCEL: begin
            if (srch_phase != PH_IDLE) begin
               srch_phase = PH_IDLE;
               canc       = 1'b1;
            end
         end
         KIND_TICK: begin
            if (srch_phase != PH_IDLE) begin
               if (elapsed != MS_MAX) elapsed++;
               case (srch_phase)
                  PH_WAIT: begin
                     if (r.heartbeat_alive) begin
                        if (hi_bound <= lo_bound + 1) begin
                           // range closed: converged
                           srch_phase = PH_IDLE;
                           fin        = 1'b1;
                        end else begin
                           probe_len  = LEN_W'((lo_bound + hi_bound) / 2);
                           srch_phase = PH_SEND;
                           elapsed    = '0;
                        end
                     end else if (elapsed > cfg_recover) begin
                        // target never came back
                        srch_phase = PH_IDLE;
                        fin        = 1'b1;
                     end
                  end
                  PH_SEND: begin
                     srch_phase = PH_OBSERVE;
                     elapsed    = '0;
                     if (probe_len > FRAME_OVERHEAD) begin
                        pay = BYTE_W'(probe_len - FRAME_OVERHEAD);
                        // checksum covers command, length, zero bytes and payload,
                        // taken before any mutation is applied
                        chk = cfg_cmd ^ pay;
                        for (int i = 0; i < pay; i++) chk ^= BYTE_W'(i);
                        if (held_mut == MUT_BAD_CHK) chk = ~chk;
                        for (int p = 0; p < probe_len; p++) begin
                           if (p == POS_SYNC)
                              b = (held_mut == MUT_SYNC) ? BYTE_ONES : cfg_sync;
                           else if (p == POS_CMD)
                              b = cfg_cmd;
                           else if (p == POS_LEN)
                              b = (held_mut == MUT_LEN) ? BYTE_ONES : pay;
                           else if (p < HDR_LEN)
                              b = BYTE_ZERO;
                           else if (p < HDR_LEN + pay)
                              b = BYTE_W'(p - HDR_LEN);
                           else if (p == HDR_LEN + pay)
                              b = chk;
                           else
                              b = BYTE_ZERO;
                           res             = '0;
                           res.byte_valid  = 1'b1;
                           res.packet_byte = b;
                           res.last        = (p + 1 == probe_len);
                           res.best_len    = best_fail;
                           res.busy_res    = 1'b1;
                           frame_status_q.push_back(res);
                        end
                        return;
                     end
                  end
                  default: begin
                     if (!r.heartbeat_alive && r.heartbeat_seen) begin
                        // heartbeat lost: this length fails, tighten the top
                        best_fail  = probe_len;
                        hi_bound   = probe_len;
                        clr        = 1'b1;
                        srch_phase = PH_WAIT;
                        elapsed    = '0;
                     end else if (elapsed >= cfg_observe) begin
                        // window ran out with the target alive: raise the bottom
                        lo_bound   = probe_len;
                        srch_phase = PH_WAIT;
                        elapsed    = '0;
                     end
                  end
               endcase
            end
         end
         default: ;
      endcase
      res                = '0;
      res.last           = 1'b1;
      res.finished       = fin;
      res.cancelled      = canc;
      res.best_len       = best_fail;
      res.clear_detector = clr;
      res.busy_res       = (srch_phase != PH_IDLE);
      frame_status_q.push_back(res);
   endtask

   // Offer one transaction in the sender's burst pattern and hold it until
   // accepted. A typed row replaces the model's single status result.
   task automatic offer(input req_type r, input bit typed, input rsp_type e);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && !req_stall));
      minimize_step(r);
      if (typed) frame_status_q[frame_status_q.size() - 1] = e;
   endtask

   // Drop valid, wait out every owed result, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (frame_status_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back while nothing is in flight.
   task automatic program_regs(input logic [BYTE_W-1:0] sync_v, input logic [BYTE_W-1:0] cmd_v,
                               input logic [MS_W-1:0] tmo_v, input logic [MS_W-1:0] obs_v);
      csr_we    <= 1'b1;
      csr_index <= CSR_SYNC_BYTE;
      csr_wdata <= CSR_W'(sync_v);
      @(posedge clock);
      csr_index <= CSR_COMMAND_BYTE;
      csr_wdata <= CSR_W'(cmd_v);
      @(posedge clock);
      csr_index <= CSR_RECOVER_TMO;
      csr_wdata <= tmo_v;
      @(posedge clock);
      csr_index <= CSR_OBSERVE_WINDOW;
      csr_wdata <= obs_v;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_sync    = sync_v;
      cfg_cmd     = cmd_v;
      cfg_recover = tmo_v;
      cfg_observe = obs_v;
   endtask

   // Random searches. Most transactions follow the search as the model sees
   // it (starts when idle, heartbeat ticks that let probes go out and fail or
   // pass); the rest are restarts, cancels and unused kinds. Only transactions
   // that the block acts on count toward the total.
   task automatic run_random(input int count);
      int      done;
      int      roll;
      req_type r;
      done = 0;
      while (done < count) begin
         r    = req_type'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 5)
            r.kind = KIND_UNUSED;
         else if (srch_phase == PH_IDLE)
            r.kind = (roll < 85) ? KIND_START : ((roll < 92) ? KIND_TICK : KIND_CANCEL);
         else if (roll < 9)
            r.kind = KIND_START;
         else if (roll < 13)
            r.kind = KIND_CANCEL;
         else begin
            r.kind = KIND_TICK;
            if (srch_phase == PH_WAIT) begin
               // mostly let the target recover so probes go out
               r.heartbeat_alive = ($urandom_range(0, 3) != 0);
               r.heartbeat_seen  = r.heartbeat_alive | 1'($urandom_range(0, 1));
            end else if (srch_phase == PH_OBSERVE && $urandom_range(0, 99) < 35) begin
               r.heartbeat_alive = 1'b0;
               r.heartbeat_seen  = 1'b1;
            end
         end
         if (r.kind == KIND_START && $urandom_range(0, 5) != 0)
            r.original_len = LEN_W'($urandom_range(FRAME_OVERHEAD + 3, MAX_FRAME));
         if (r.kind == KIND_START || (srch_phase != PH_IDLE && r.kind != KIND_UNUSED))
            done++;
         offer(r, 1'b0, '0);
      end
   endtask

   // ----- receiver: stall pattern in modes, plus one long hold-off -----
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (hold_request) begin
            // hold off long enough for the output to fill and stall the input
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_stall   <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(16, 64);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // ----- result checker: every accepted result against the oldest owed one -----
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR cycle %0d: result with nothing owed: %h", cycle_count, rsp_data);
         end else begin
            want_rsp = frame_status_q.pop_front();
            if (rsp_data !== want_rsp) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("ERROR cycle %0d: result mismatch", cycle_count);
                  $display("  exp v=%0d b=%h l=%0d fin=%0d canc=%0d best=%0d clr=%0d busy=%0d",
                           want_rsp.byte_valid, want_rsp.packet_byte, want_rsp.last,
                           want_rsp.finished, want_rsp.cancelled, want_rsp.best_len,
                           want_rsp.clear_detector, want_rsp.busy_res);
                  $display("  got v=%0d b=%h l=%0d fin=%0d canc=%0d best=%0d clr=%0d busy=%0d",
                           rsp_data.byte_valid, rsp_data.packet_byte, rsp_data.last,
                           rsp_data.finished, rsp_data.cancelled, rsp_data.best_len,
                           rsp_data.clear_detector, rsp_data.busy_res);
               end
            end
         end
      end
   end

   // ----- watchdog -----
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("packet_length_minimizer test failed");
      $finish;
   end

   // ----- stimulus -----
   initial begin
      // model at reset
      cfg_sync    = SYNC_RESET;
      cfg_cmd     = COMMAND_RESET;
      cfg_recover = RECOVER_RESET;
      cfg_observe = OBSERVE_RESET;
      srch_phase  = PH_IDLE;
      lo_bound    = '0;
      hi_bound    = '0;
      probe_len   = '0;
      best_fail   = '0;
      elapsed     = '0;
      held_mut    = MUT_NONE;

      // Directed table, at the reset register values. Rows with a typed
      // expectation are plain status results; the rest go through the model.
      // idle block: tick, cancel and the unused kind change nothing
      add_row(make_req(KIND_TICK, 127, MUT_LEN, 1, 1), 1, status_rsp(0, 0, 0, 0));
      add_row(make_req(KIND_CANCEL, 0, MUT_NONE, 0, 0), 1, status_rsp(0, 0, 0, 0));
      add_row(make_req(KIND_UNUSED, 85, MUT_SYNC, 1, 0), 1, status_rsp(0, 0, 0, 0));
      // oversize start clamps to the frame limit
      add_row(make_req(KIND_START, 127, MUT_LEN, 0, 0), 1, status_rsp(0, 0, 64, 1));
      // restart with a zero length: range already closed
      add_row(make_req(KIND_START, 0, MUT_NONE, 0, 0), 1, status_rsp(0, 0, 0, 1));
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 1, status_rsp(1, 0, 0, 0));
      // length just above the overhead: one dead tick, then converge
      add_row(make_req(KIND_START, 8, MUT_BAD_CHK, 0, 0), 1, status_rsp(0, 0, 8, 1));
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 0, 1), 1, status_rsp(0, 0, 8, 1));
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 1, status_rsp(1, 0, 8, 0));
      // full-size search, broken sync: probe, ignore a quiet tick, then fail twice
      add_row(make_req(KIND_START, 64, MUT_SYNC, 0, 0), 1, status_rsp(0, 0, 64, 1));
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 0, '0);
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 0, '0);
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 0, 0), 0, '0);
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 0, 1), 0, '0);
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 0, '0);
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 0, '0);
      add_row(make_req(KIND_UNUSED, 127, MUT_LEN, 1, 1), 0, '0);
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 0, 1), 0, '0);
      // cancel while busy keeps the best length
      add_row(make_req(KIND_CANCEL, 0, MUT_NONE, 0, 0), 1, status_rsp(0, 1, 21, 0));
      // bad checksum probe, then a restart while observing
      add_row(make_req(KIND_START, 40, MUT_BAD_CHK, 1, 1), 1, status_rsp(0, 0, 40, 1));
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 0, '0);
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 0, '0);
      add_row(make_req(KIND_START, 100, MUT_NONE, 0, 0), 1, status_rsp(0, 0, 64, 1));
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 0, '0);
      add_row(make_req(KIND_TICK, 0, MUT_NONE, 1, 1), 0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_item[i]) offer(dir_item[i], dir_typed[i], dir_exp[i]);
      drain();

      // low extremes: zero sync byte, all-ones command byte, a short timeout, zero observe window
      program_regs(BYTE_ZERO, BYTE_ONES, 16'd1, 16'd0);
      run_random(18);
      drain();

      // high extremes: the wait never times out, windows end only on loss
      program_regs(BYTE_ONES, BYTE_ZERO, MS_MAX, MS_MAX);
      run_random(18);
      drain();

      // short windows; hold the receiver off while the sender keeps going,
      // then pause the sender until everything owed has come back
      program_regs(BYTE_W'($urandom), BYTE_W'($urandom),
                   MS_W'($urandom_range(2, 12)), MS_W'($urandom_range(1, 4)));
      hold_request = 1'b1;
      run_random(9);
      drain();
      run_random(9);
      drain();

      program_regs(BYTE_W'($urandom), BYTE_W'($urandom), 16'd1, 16'd1);
      run_random(18);
      drain();

      if (mismatches == 0 && frame_status_q.size() == 0) begin
         $display("packet_length_minimizer test passed");
      end else begin
         $display("packet_length_minimizer test failed");
      end
      $finish;
   end

endmodule
